FILE: design/fpfa_pkg.sv
// fpfa_pkg: shared types and codes of the fixed partition fit allocator
// used by fpfa_pick and the top level; depends on nothing
`timescale 1ns / 1ps

package fpfa_pkg;

	localparam logic [1:0] CMD_LOAD  = 2'd0;
	localparam logic [1:0] CMD_ALLOC = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE        = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 1'd1;

	localparam logic FIT_BEST  = 1'b0;
	localparam logic FIT_FIRST = 1'b1;

	localparam logic [5:0] COUNT_RESET = 6'd32;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [4:0]  entry_index;
		logic [15:0] size_value;
	} req_t;

	typedef struct packed {
		logic        found;
		logic [4:0]  chosen_index;
		logic [15:0] leftover;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

endpackage

FILE: design/fpfa_ram.sv
// fpfa_ram: generic simple dual port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module fpfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/fpfa_pick.sv
// fpfa_pick: compares each scanned partition with the request and keeps the best
// candidate so far, or the first fitting one in first fit mode; depends on fpfa_pkg
`timescale 1ns / 1ps

module fpfa_pick #(
	parameter int IDX_W     = 5,
	parameter int SIZE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 eval,
	input  logic                 fit_mode,
	input  logic                 used,
	input  logic [SIZE_BITS-1:0] psize,
	input  logic [SIZE_BITS-1:0] req_size,
	input  logic [IDX_W-1:0]     idx,
	output logic                 have,
	output logic [IDX_W-1:0]     best_idx,
	output logic [SIZE_BITS-1:0] best_left
);

	logic                 have_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [SIZE_BITS-1:0] best_left_q;
	logic                 fits;
	logic [SIZE_BITS-1:0] left;
	logic                 take;

	assign fits = !used && (psize >= req_size);
	assign left = psize - req_size;
	assign take = eval && fits &&
		!(have_q && ((fit_mode == fpfa_pkg::FIT_FIRST) || (left >= best_left_q)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (start) begin
			have_q <= 1'b0;
		end else if (take) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_idx_q  <= idx;
			best_left_q <= left;
		end
	end

	assign have      = have_q;
	assign best_idx  = best_idx_q;
	assign best_left = best_left_q;

endmodule

FILE: design/fixed_partition_fit_allocator.sv
// fixed_partition_fit_allocator: top level, request and result channels, config
// registers, scan sequencer and used marks; depends on fpfa_pkg, fpfa_ram, fpfa_pick
`timescale 1ns / 1ps

// Keeps a table of partition sizes in a ram plus one used mark per partition.
// A load request writes one size and frees that partition, a clear request frees
// all of them; both are applied when accepted and give no result. An allocate request scans
// the table one entry per cycle through the ram read port and returns one result;
// the scan covers n entries, n being min(partition_count, NUM_PARTITIONS), and
// stops earlier in first fit mode, at the first hit.
// The size table has no reset and needs no clearing pass; used marks are cleared
// at reset. Configuration is accepted at any time but must only change while idle.
module fixed_partition_fit_allocator #(
	parameter int NUM_PARTITIONS = 32,
	parameter int SIZE_BITS      = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  fpfa_pkg::req_t                      req_data,
	output logic                                res_valid,
	input  logic                                res_ready,
	output fpfa_pkg::res_t                      res_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int IDX_W = $clog2(NUM_PARTITIONS);
	localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);

	fpfa_pkg::state_t      state_q;
	logic                  fit_mode_q;
	logic [5:0]            count_q;
	logic [CNT_W-1:0]      scan_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      n_eff;
	logic [SIZE_BITS-1:0]  req_q;
	logic                  rd_v_s1;
	logic [IDX_W-1:0]      rd_idx_s1;
	logic                  used_s1;
	logic [NUM_PARTITIONS-1:0] used_q;
	fpfa_pkg::res_t        res_q;
	logic                  res_valid_q;

	logic                  req_acc;
	logic                  do_load;
	logic                  do_alloc;
	logic                  do_clear;
	logic                  issue;
	logic [IDX_W-1:0]      scan_addr;
	logic [IDX_W-1:0]      load_addr;
	logic [SIZE_BITS-1:0]  rdata;
	logic                  have;
	logic [IDX_W-1:0]      best_idx;
	logic [SIZE_BITS-1:0]  best_left;
	logic                  load_out;

	// request decode
	assign req_ready = (state_q == fpfa_pkg::ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign do_load   = req_acc && (req_data.cmd == fpfa_pkg::CMD_LOAD) &&
		(32'(req_data.entry_index) < 32'(NUM_PARTITIONS));
	assign do_alloc  = req_acc && (req_data.cmd == fpfa_pkg::CMD_ALLOC);
	assign do_clear  = req_acc && (req_data.cmd == fpfa_pkg::CMD_CLEAR);
	assign load_addr = IDX_W'(req_data.entry_index);

	assign n_eff = (32'(count_q) > 32'(NUM_PARTITIONS)) ?
		CNT_W'(NUM_PARTITIONS) : CNT_W'(count_q);

	// scan control
	assign scan_addr = scan_q[IDX_W-1:0];
	assign issue     = (state_q == fpfa_pkg::ST_SCAN) && (scan_q < n_q) &&
		!((fit_mode_q == fpfa_pkg::FIT_FIRST) && have);
	assign load_out  = (state_q == fpfa_pkg::ST_DONE) && (!res_valid_q || res_ready);

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= fpfa_pkg::FIT_BEST;
			count_q    <= fpfa_pkg::COUNT_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fpfa_pkg::CFG_FIT_MODE:        fit_mode_q <= cfg_data[0];
				fpfa_pkg::CFG_PARTITION_COUNT: count_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpfa_pkg::ST_IDLE;
			scan_q  <= '0;
			n_q     <= '0;
			rd_v_s1 <= 1'b0;
		end else begin
			rd_v_s1 <= issue;
			unique case (state_q)
				fpfa_pkg::ST_IDLE: begin
					if (do_alloc) begin
						state_q <= fpfa_pkg::ST_SCAN;
						scan_q  <= '0;
						n_q     <= n_eff;
					end
				end
				fpfa_pkg::ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end else if (!rd_v_s1) begin
						state_q <= fpfa_pkg::ST_DONE;
					end
				end
				fpfa_pkg::ST_DONE: begin
					if (load_out) begin
						state_q <= fpfa_pkg::ST_IDLE;
					end
				end
				default: state_q <= fpfa_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_alloc) begin
			req_q <= SIZE_BITS'(req_data.size_value);
		end
		if (issue) begin
			rd_idx_s1 <= scan_addr;
			used_s1   <= used_q[scan_addr];
		end
	end

	// used marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (do_clear) begin
			used_q <= '0;
		end else if (do_load) begin
			used_q[load_addr] <= 1'b0;
		end else if (load_out && have) begin
			used_q[best_idx] <= 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			res_q.found        <= have;
			res_q.chosen_index <= have ? 5'(best_idx) : 5'd0;
			res_q.leftover     <= have ? 16'(best_left) : 16'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	fpfa_ram #(
		.WIDTH (SIZE_BITS),
		.DEPTH (NUM_PARTITIONS)
	) u_size_ram (
		.clk   (clk),
		.we    (do_load),
		.waddr (load_addr),
		.wdata (SIZE_BITS'(req_data.size_value)),
		.re    (issue),
		.raddr (scan_addr),
		.rdata (rdata)
	);

	fpfa_pick #(
		.IDX_W     (IDX_W),
		.SIZE_BITS (SIZE_BITS)
	) u_pick (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (do_alloc),
		.eval      (rd_v_s1),
		.fit_mode  (fit_mode_q),
		.used      (used_s1),
		.psize     (rdata),
		.req_size  (req_q),
		.idx       (rd_idx_s1),
		.have      (have),
		.best_idx  (best_idx),
		.best_left (best_left)
	);

	// a granted partition must be free and inside the active range
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && have) |-> !used_q[best_idx])
		else $error("granted partition already used");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && have) |-> (CNT_W'(best_idx) < n_q))
		else $error("granted partition outside active count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fpfa_pkg::ST_SCAN) |-> (scan_q <= n_q))
		else $error("scan counter past active count");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_v_s1 |-> $past(state_q == fpfa_pkg::ST_SCAN))
		else $error("ram read outside scan");

endmodule
